// File: sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and character functions for the base64 stream
// decoder: word formats, decode state, result bundle and alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Config port
  localparam int PADDR_W = 1;
  localparam logic [PADDR_W-1:0] REG_URL_MODE = 1'b0;

  // Characters and symbol marker
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [6:0] SYM_MARKER = 7'd64;

  // Input and output words
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_of_run;
  } out_word_t;

  // Percent-escape phase
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_t;

  // Decoder state
  typedef struct packed {
    logic [1:0]      sym_count;
    logic [2:0][6:0] group;
    esc_phase_t      phase;
    logic [7:0]      first_digit;
  } dec_state_t;

  // Bytes produced by one character, packed from index 0
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } res_t;

  // Standard alphabet lookup; anything else is the marker
  function automatic logic [6:0] map_symbol(input logic [7:0] c);
    logic [7:0] d;
    d = {1'b0, SYM_MARKER};
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == CHAR_PLUS) begin
      d = 8'd62;
    end else if (c == CHAR_SLASH) begin
      d = 8'd63;
    end
    return d[6:0];
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

// File: sv/b64d_core.sv
// ----------------------------------------------------------------------------
// b64d_core
// Decode state and next-state logic: percent-escape handling, symbol
// mapping, group assembly and byte extraction for one character.
// ----------------------------------------------------------------------------
module b64d_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               url_mode,
  input  logic               adv,
  input  b64d_pkg::in_word_t word,
  output b64d_pkg::res_t     res
);

  b64d_pkg::dec_state_t state;
  b64d_pkg::dec_state_t state_next;

  // State register, updated when a character is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_comb begin : decode
    logic [7:0]      c;
    logic            start;
    logic            c_hex;
    logic [2:0]      pv;
    logic [2:0][7:0] pc;
    logic [1:0]      cnt;
    logic [2:0][6:0] grp;
    logic [6:0]      s;
    logic            emitted;
    logic [7:0]      b0, b1, b2;
    logic            b1v, b2v;

    c       = word.char_in;
    start   = url_mode && (c == b64d_pkg::CHAR_PCT);
    c_hex   = b64d_pkg::is_hex(c);
    pv      = '0;
    pc      = '0;
    emitted = 1'b0;
    b0      = '0;
    b1      = '0;
    b2      = '0;
    b1v     = 1'b0;
    b2v     = 1'b0;
    s       = '0;
    state_next = state;

    // Characters pushed into the group, in order, up to three
    unique case (state.phase)
      b64d_pkg::ESC_PCT: begin
        if (c_hex) begin
          state_next.phase       = b64d_pkg::ESC_DIGIT;
          state_next.first_digit = c;
          if (word.end_of_text) begin
            pv = 3'b011;
            pc[0] = b64d_pkg::CHAR_PCT;
            pc[1] = c;
          end
        end else begin
          pv[0] = 1'b1;
          pc[0] = b64d_pkg::CHAR_PCT;
          if (start) begin
            state_next.phase = b64d_pkg::ESC_PCT;
            if (word.end_of_text) begin
              pv[1] = 1'b1;
              pc[1] = b64d_pkg::CHAR_PCT;
            end
          end else begin
            state_next.phase = b64d_pkg::ESC_NONE;
            pv[1] = 1'b1;
            pc[1] = c;
          end
        end
      end
      b64d_pkg::ESC_DIGIT: begin
        if (c_hex) begin
          state_next.phase = b64d_pkg::ESC_NONE;
          pv[0] = 1'b1;
          pc[0] = {b64d_pkg::hex_value(state.first_digit), b64d_pkg::hex_value(c)};
        end else begin
          pv[1:0] = 2'b11;
          pc[0] = b64d_pkg::CHAR_PCT;
          pc[1] = state.first_digit;
          if (start) begin
            state_next.phase = b64d_pkg::ESC_PCT;
            if (word.end_of_text) begin
              pv[2] = 1'b1;
              pc[2] = b64d_pkg::CHAR_PCT;
            end
          end else begin
            state_next.phase = b64d_pkg::ESC_NONE;
            pv[2] = 1'b1;
            pc[2] = c;
          end
        end
      end
      default: begin
        if (start) begin
          state_next.phase = b64d_pkg::ESC_PCT;
          if (word.end_of_text) begin
            pv[0] = 1'b1;
            pc[0] = b64d_pkg::CHAR_PCT;
          end
        end else begin
          state_next.phase = b64d_pkg::ESC_NONE;
          pv[0] = 1'b1;
          pc[0] = c;
        end
      end
    endcase

    // Group assembly; at most one group completes per character
    cnt = state.sym_count;
    grp = state.group;
    for (int i = 0; i < 3; i++) begin
      if (pv[i]) begin
        s = b64d_pkg::map_symbol(pc[i]);
        if (cnt == 2'd3) begin
          emitted = 1'b1;
          b0  = {grp[0][5:0], 2'b00} + {5'b0, grp[1][6:4]};
          b1  = {grp[1][3:0], 4'b0000} + {3'b0, grp[2][6:2]};
          b2  = {grp[2][1:0], 6'b0} + {1'b0, s};
          b1v = (grp[2] != b64d_pkg::SYM_MARKER);
          b2v = (s != b64d_pkg::SYM_MARKER);
          cnt = 2'd0;
        end else begin
          grp[cnt] = s;
          cnt = cnt + 2'd1;
        end
      end
    end

    // End of text drops the open group and any escape
    if (word.end_of_text) begin
      state_next.phase = b64d_pkg::ESC_NONE;
      cnt = 2'd0;
      grp = '0;
    end
    state_next.sym_count = cnt;
    state_next.group     = grp;

    // Pack emitted bytes
    res.bytes[0] = b0;
    res.bytes[1] = b1v ? b1 : b2;
    res.bytes[2] = b2;
    if (!emitted) begin
      res.count = 2'd0;
    end else if (b1v && b2v) begin
      res.count = 2'd3;
    end else if (b1v || b2v) begin
      res.count = 2'd2;
    end else begin
      res.count = 2'd1;
    end
  end

endmodule

// File: sv/b64d_outbuf.sv
// ----------------------------------------------------------------------------
// b64d_outbuf
// Result register: holds up to three bytes from one character and hands
// them out one word per cycle while out_ready is high, flagging the final one.
// ----------------------------------------------------------------------------
module b64d_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  b64d_pkg::res_t      res,
  input  logic                out_ready,
  output logic                out_valid,
  output b64d_pkg::out_word_t out_data,
  output logic                free
);

  logic [1:0]      rem;
  logic [2:0][7:0] bytes;
  logic            take;

  assign out_valid = (rem != 2'd0);
  assign take      = out_valid && out_ready;
  // Room for the next character's bytes this cycle
  assign free      = (rem == 2'd0) || (take && rem == 2'd1);

  assign out_data.byte_out    = bytes[0];
  assign out_data.last_of_run = (rem == 2'd1);

  // Remaining count
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= res.count;
    end else if (take) begin
      rem <= rem - 2'd1;
    end
  end

  // Byte shift line
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
    end else if (take) begin
      bytes[0] <= bytes[1];
      bytes[1] <= bytes[2];
    end
  end

endmodule

// File: sv/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder with optional percent-escape decoding of the
// input text, an input register, and a serializing result register.
// ----------------------------------------------------------------------------
//  channel | signals                               | word
//  --------+---------------------------------------+---------------------------
//  input   | in_valid, in_ready, in_data           | char_in, end_of_text
//  output  | out_valid, out_ready, out_data        | byte_out, last_of_run
//  config  | psel, penable, pwrite, paddr, pwdata, | url_mode at address 0
//          | prdata, pready                        |
//
//  One character is decoded per cycle while the result register has room: it
//  waits in the input register, then moves into the result register with its bytes.
//  A character that completes a group yields up to three words, one per
//  cycle while out_ready is high, so sustained input rate is bounded by the output port.
//  Synchronous reset clears the decode state, url_mode and both valid flags.
//  in_ready drops only while a held character waits on words still owed.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  b64d_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output b64d_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [b64d_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic               url_mode;
  logic               stg_vld;
  b64d_pkg::in_word_t stg_word;
  logic               adv;
  logic               buf_free;
  b64d_pkg::res_t     res;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr == b64d_pkg::REG_URL_MODE) ? {31'b0, url_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr == b64d_pkg::REG_URL_MODE) begin
      url_mode <= pwdata[0];
    end
  end

  // Input register
  assign adv      = stg_vld && buf_free;
  assign in_ready = !stg_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_vld <= 1'b1;
    end else if (adv) begin
      stg_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_word <= in_data;
    end
  end

  b64d_core u_core (
    .clk      (clk),
    .rst      (rst),
    .url_mode (url_mode),
    .adv      (adv),
    .word     (stg_word),
    .res      (res)
  );

  b64d_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (buf_free)
  );

  // Input stalls only behind pending output
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // Bytes loaded show up on the output next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (adv && res.count != 2'd0) |=> out_valid)
    else $error("loaded bytes not presented");

  // A word taken without the last flag leaves more to send
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last_of_run) |=> out_valid)
    else $error("run ended without last flag");

endmodule
